// ===== src/anp_pkg.sv =====
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types and constants for the ascii number parser: payload structs,
// the classified character record and the character codes it looks for.
// ----------------------------------------------------------------------------
package anp_pkg;

  // longest string that still fits: one prefix/terminator slot beyond digits
  localparam int MaxChars = 11;
  localparam int CharPosW = 4;
  localparam int ValueW   = 32;

  // decoupling queue between classifier and execution stage
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpF   = 8'h46;
  localparam logic [7:0] ChrUpK   = 8'h4B;
  localparam logic [7:0] ChrUpM   = 8'h4D;
  localparam logic [7:0] ChrUpX   = 8'h58;
  localparam logic [7:0] ChrLowA  = 8'h61;
  localparam logic [7:0] ChrLowF  = 8'h66;
  localparam logic [7:0] ChrLowK  = 8'h6B;
  localparam logic [7:0] ChrLowM  = 8'h6D;
  localparam logic [7:0] ChrLowX  = 8'h78;

  // letter digits a-f / A-F: low nibble plus this gives 10..15
  localparam logic [3:0] HexLetterAdj = 4'd9;

  // shift amounts for the kilo and mega suffixes
  localparam int KiloShift = 10;
  localparam int MegaShift = 20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] value;
  } out_t;

  // one character after classification
  typedef struct packed {
    logic       start;
    logic       is_nul;
    logic       is_x;
    logic       is_k;
    logic       is_m;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
  } cls_t;

  typedef struct packed {
    logic             full;
    logic [QCntW-1:0] count;
  } q_status_t;

endpackage

// ===== src/anp_front.sv =====
// ----------------------------------------------------------------------------
// anp_front
// Front end: takes characters from the input channel and decodes them into
// a classified record (digit value, terminator, suffix and prefix flags).
// ----------------------------------------------------------------------------
module anp_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  anp_pkg::in_t  in_data_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output anp_pkg::cls_t push_data_o
);
  import anp_pkg::*;

  logic [7:0] c;
  logic       lower_hex;
  logic       upper_hex;

  assign c            = in_data_i.char_code;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    lower_hex = (c >= ChrLowA) && (c <= ChrLowF);
    upper_hex = (c >= ChrUpA) && (c <= ChrUpF);

    push_data_o.start  = in_data_i.string_start;
    push_data_o.is_nul = (c == ChrNul);
    push_data_o.is_x   = (c == ChrLowX) || (c == ChrUpX);
    push_data_o.is_k   = (c == ChrLowK) || (c == ChrUpK);
    push_data_o.is_m   = (c == ChrLowM) || (c == ChrUpM);
    push_data_o.is_dec = (c >= ChrZero) && (c <= ChrNine);
    push_data_o.is_hex = push_data_o.is_dec || lower_hex || upper_hex;
    // ascii digits and letters share the low nibble layout
    push_data_o.digit  = push_data_o.is_dec ? c[3:0] : c[3:0] + HexLetterAdj;
  end

endmodule

// ===== src/anp_queue.sv =====
// ----------------------------------------------------------------------------
// anp_queue
// Small fifo of classified characters that decouples the front end from the
// execution stage; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module anp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  anp_pkg::cls_t      push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output anp_pkg::cls_t      pop_data_o,
  output anp_pkg::q_status_t status_o
);
  import anp_pkg::*;

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign status_o.full  = !push_ready_o;
  assign status_o.count = count_q;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/anp_back.sv =====
// ----------------------------------------------------------------------------
// anp_back
// Execution stage: holds parse state, applies one classified character per
// cycle while the output register can take a result, which it places there.
// ----------------------------------------------------------------------------
module anp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  anp_pkg::cls_t q_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output anp_pkg::out_t out_data_o
);
  import anp_pkg::*;

  logic [CharPosW-1:0] pos_q, pos_d;
  logic                hex_q, hex_d;
  logic                decided_q, decided_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q, out_data_d;

  logic [CharPosW-1:0] pos;
  logic                hex;
  logic [ValueW-1:0]   acc;
  logic                active;
  logic                done;
  logic                ok;
  logic [ValueW-1:0]   val;
  logic                hex_n;
  logic [ValueW-1:0]   acc_n;

  // take a character whenever the output register can hold a new result
  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    // a string start clears the state before the character is applied
    pos    = q_data_i.start ? '0 : pos_q;
    hex    = q_data_i.start ? 1'b0 : hex_q;
    acc    = q_data_i.start ? '0 : acc_q;
    active = q_data_i.start || !decided_q;

    done  = 1'b0;
    ok    = 1'b0;
    val   = '0;
    hex_n = hex;
    acc_n = acc;

    if (hex) begin
      if (q_data_i.is_nul) begin
        done = 1'b1;
        ok   = 1'b1;
        val  = acc;
      end else if (pos >= CharPosW'(MaxChars) || !q_data_i.is_hex) begin
        done = 1'b1;
      end else begin
        acc_n = {acc[ValueW-5:0], q_data_i.digit};
      end
    end else begin
      if (pos == CharPosW'(1) && acc == '0 && q_data_i.is_x) begin
        hex_n = 1'b1;
      end else if (q_data_i.is_nul) begin
        done = 1'b1;
        ok   = 1'b1;
        val  = acc;
      end else if (q_data_i.is_k && pos != '0) begin
        done = 1'b1;
        ok   = 1'b1;
        val  = acc << KiloShift;
      end else if (q_data_i.is_m && pos != '0) begin
        done = 1'b1;
        ok   = 1'b1;
        val  = acc << MegaShift;
      end else if (q_data_i.is_dec && pos < CharPosW'(MaxChars - 1)) begin
        // times ten as two shifts and an add
        acc_n = (acc << 3) + (acc << 1) + ValueW'(q_data_i.digit);
      end else begin
        done = 1'b1;
      end
    end

    pos_d     = pos_q;
    hex_d     = hex_q;
    decided_d = decided_q;
    acc_d     = acc_q;
    if (pop_o && active) begin
      hex_d     = hex_n;
      acc_d     = acc_n;
      decided_d = done;
      if (done || pos == '1) begin
        pos_d = pos;
      end else begin
        pos_d = pos + 1'b1;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (pop_o && active && done) begin
      out_valid_d      = 1'b1;
      out_data_d.ok    = ok;
      out_data_d.value = val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hex_q       <= 1'b0;
      decided_q   <= 1'b1;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hex_q       <= hex_d;
      decided_q   <= decided_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

// ===== src/ascii_number_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_number_parser_core
// Parses a stream of ascii characters into 32-bit unsigned values.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while the queue has room,
// and answers each string with a single (ok, value) transaction once its
// outcome is known: a 0x/0X prefix selects hex, otherwise decimal with
// optional k/m suffix. A character is decoded in the front end, waits in a
// two-entry queue and is applied by the execution stage, whose shift-add
// update sets the rate of one character per cycle; the deciding character
// is registered in the queue and its result in the output register.
// Back-pressure on the output only stalls input once the queue has filled.
// Characters before the first string start or after a decision are consumed
// without a result.
module ascii_number_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  anp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output anp_pkg::out_t out_data_o
);
  import anp_pkg::*;

  logic      push_valid;
  logic      push_ready;
  cls_t      push_data;
  logic      q_valid;
  cls_t      q_data;
  logic      pop;
  q_status_t q_status;

  anp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  anp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_i        (pop),
    .pop_data_o   (q_data),
    .status_o     (q_status)
  );

  anp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a failed parse always reports a zero value
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.value == '0)
    else $error("invalid result carries nonzero value");

  // a new result only follows a character taken from the queue
  a_result_from_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop))
    else $error("result without a consumed character");

  // the execution stage never pops an empty queue
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid && q_status.count != '0)
    else $error("pop from empty queue");

  // input is only taken while the queue has room
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !q_status.full && q_status.count != QCntW'(QDepth))
    else $error("character accepted into full queue");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ascii_number_parser_core: strings of characters go
// in one per transaction, a cycle-level string parser predicts each (ok,
// value) result and the monitor compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import anp_pkg::*;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1
  } radix_e;

  typedef logic [7:0] chr_q_t[$];

  localparam int NumChars = 1150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  char_fifo[$];
  out_t parsed_q[$];

  // string parser state
  logic [3:0]  scan_pos;
  radix_e      scan_mode;
  bit          scan_done;
  logic [31:0] scan_acc;

  bit steady = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int live_chars = 0;
  int n_strings = 0;
  int n_ok = 0;
  int n_bad = 0;

  ascii_number_parser_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void parse_char(input in_t ch, output bit live, output bit emits,
                                     output out_t res);
    logic [7:0]  c;
    logic [3:0]  nib;
    bit          is_hex_dig;
    bit          done;
    bit          good;
    logic [31:0] val;
    c = ch.char_code;
    done = 1'b0;
    good = 1'b0;
    val = '0;
    res = '0;
    emits = 1'b0;
    live = 1'b1;
    if (ch.string_start) begin
      scan_pos = '0;
      scan_mode = RADIX_DEC;
      scan_done = 1'b0;
      scan_acc = '0;
    end else if (scan_done) begin
      live = 1'b0;
      return;
    end
    is_hex_dig = 1'b1;
    nib = '0;
    if (c >= ChrZero && c <= ChrNine) nib = 4'(c - ChrZero);
    else if (c >= ChrLowA && c <= ChrLowF) nib = 4'(c - ChrLowA + 8'd10);
    else if (c >= ChrUpA && c <= ChrUpF) nib = 4'(c - ChrUpA + 8'd10);
    else is_hex_dig = 1'b0;

    if (scan_mode == RADIX_HEX) begin
      if (c == ChrNul) begin
        done = 1'b1;
        good = 1'b1;
        val = scan_acc;
      end else if (scan_pos >= MaxChars || !is_hex_dig) begin
        done = 1'b1;
      end else begin
        scan_acc = {scan_acc[27:0], nib};
      end
    end else begin
      if (scan_pos == 4'd1 && scan_acc == '0 && (c == ChrLowX || c == ChrUpX)) begin
        scan_mode = RADIX_HEX;
      end else if (c == ChrNul) begin
        done = 1'b1;
        good = 1'b1;
        val = scan_acc;
      end else if ((c == ChrLowK || c == ChrUpK) && scan_pos != '0) begin
        done = 1'b1;
        good = 1'b1;
        val = scan_acc << KiloShift;
      end else if ((c == ChrLowM || c == ChrUpM) && scan_pos != '0) begin
        done = 1'b1;
        good = 1'b1;
        val = scan_acc << MegaShift;
      end else if (c >= ChrZero && c <= ChrNine && int'(scan_pos) + 1 < MaxChars) begin
        scan_acc = scan_acc * 32'd10 + 32'(c - ChrZero);
      end else begin
        done = 1'b1;
      end
    end

    if (!done) begin
      if (scan_pos != 4'hF) scan_pos = scan_pos + 4'd1;
    end else begin
      scan_done = 1'b1;
      emits = 1'b1;
      res.ok = good;
      res.value = good ? val : '0;
    end
  endfunction

  // driver: predicts on each accepted transaction, then offers the next one
  always @(posedge clk_i) begin
    bit   live;
    bit   emits;
    out_t res;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      scan_pos = '0;
      scan_mode = RADIX_DEC;
      scan_done = 1'b1;
      scan_acc = '0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_data, live, emits, res);
        n_sent++;
        if (live) live_chars++;
        if (emits) parsed_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (char_fifo.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
          in_valid <= 1'b1;
          in_data <= char_fifo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual ok=%0b value=%h",
                   $time, out_data.ok, out_data.value);
          errors++;
        end else begin
          want = parsed_q.pop_front();
          if (out_data.ok !== want.ok) begin
            $display("%0t: ok mismatch expected %0b actual %0b", $time, want.ok, out_data.ok);
            errors++;
          end
          if (out_data.value !== want.value) begin
            $display("%0t: value mismatch expected %h actual %h",
                     $time, want.value, out_data.value);
            errors++;
          end
          if (want.ok) n_ok++;
          else n_bad++;
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  task automatic send_string(input chr_q_t s, input bit with_start);
    in_t item;
    for (int i = 0; i < s.size(); i++) begin
      while (char_fifo.size() >= 16) @(posedge clk_i);
      item.char_code = s[i];
      item.string_start = with_start && (i == 0);
      char_fifo.push_back(item);
    end
    if (with_start) n_strings++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return ChrZero + 8'(v);
    return ($urandom_range(0, 1) ? ChrUpA : ChrLowA) + 8'(v) - 8'd10;
  endfunction

  function automatic chr_q_t dec_string();
    chr_q_t s;
    int     n;
    bit     nines;
    n = ($urandom_range(0, 9) == 0) ? 11 : $urandom_range(1, 10);
    nines = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < n; i++)
      s.push_back(nines ? ChrNine : ChrZero + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 4))
      0: s.push_back(ChrNul);
      1: s.push_back(ChrLowK);
      2: s.push_back(ChrUpK);
      3: s.push_back(ChrLowM);
      default: s.push_back(ChrUpM);
    endcase
    return s;
  endfunction

  function automatic chr_q_t hex_string();
    chr_q_t s;
    int     n;
    s.push_back(ChrZero);
    s.push_back($urandom_range(0, 1) ? ChrLowX : ChrUpX);
    n = ($urandom_range(0, 9) == 0) ? 10 : $urandom_range(0, 9);
    for (int i = 0; i < n; i++) s.push_back(hex_char(4'($urandom_range(0, 15))));
    s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : ChrNul);
    return s;
  endfunction

  task automatic send_random_string();
    chr_q_t s;
    chr_q_t tail;
    int     kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      s = dec_string();
    end else if (kind < 70) begin
      s = hex_string();
    end else if (kind < 85) begin
      // broken: one byte replaced, or the string cut short
      s = $urandom_range(0, 1) ? dec_string() : hex_string();
      if ($urandom_range(0, 1)) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      else s = s[0:$urandom_range(0, s.size() - 1)];
    end else begin
      repeat ($urandom_range(1, 14)) s.push_back(8'($urandom_range(0, 255)));
    end
    send_string(s, 1'b1);
    // trailing characters with no start; dropped if the string is decided
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) tail.push_back(8'($urandom_range(0, 255)));
      send_string(tail, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (char_fifo.size() != 0 || in_valid || parsed_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int nstr;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing counts before the first string start
    send_string('{ChrUpA}, 1'b0);
    // suffix as the first character
    send_string('{ChrLowK}, 1'b1);
    send_string('{8'h37, ChrUpM}, 1'b1);
    send_string('{8'h35, ChrUpK}, 1'b1);
    send_string('{ChrZero, ChrLowX, 8'h31, ChrLowF, ChrNul}, 1'b1);
    send_string('{ChrZero, ChrUpX, 8'h67}, 1'b1);
    // x out of the prefix slot
    send_string('{8'h31, ChrLowX}, 1'b1);
    // restart before the first string is decided
    send_string('{8'h33, 8'h32}, 1'b1);
    send_string('{ChrNine, ChrNul}, 1'b1);
    send_string('{8'hFF}, 1'b0);
    send_string('{8'hFF}, 1'b1);
    send_string('{ChrNul}, 1'b1);

    nstr = 0;
    while (n_sent < NumChars) begin
      steady = (nstr >= 30 && nstr < 70);
      if (nstr == 90) wait_drained();
      send_random_string();
      nstr++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (parsed_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, parsed_q.size());
      errors++;
    end
    $display("ran %0d strings, %0d characters, %0d non-ignored", n_strings, n_sent,
             live_chars);
    $display("checked %0d valid and %0d rejected parses, %0d errors", n_ok, n_bad, errors);
    if (errors == 0) begin
      $display("[ascii_number_parser_core] OK");
    end else begin
      $display("[ascii_number_parser_core] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("[ascii_number_parser_core] ERROR");
    $finish;
  end

endmodule
